// File: hw/rtl/mrpc_pkg.sv
// Package for the residual pixel coder: sizes, register indexes and the
// median edge predictor shared by the core. No dependencies.
`default_nettype none

package mrpc_pkg;

	localparam int MAX_WIDTH = 4096;
	localparam int COL_W     = $clog2(MAX_WIDTH);
	localparam int PIX_W     = 24;
	localparam int FW_W      = 13;
	localparam int FH_W      = 16;
	localparam int ADDR_W    = 4;
	localparam int DATA_W    = 32;

	localparam logic [1:0] REG_DECODE_MODE  = 2'd0;
	localparam logic [1:0] REG_FRAME_WIDTH  = 2'd1;
	localparam logic [1:0] REG_FRAME_HEIGHT = 2'd2;

	localparam logic [FW_W-1:0] FRAME_WIDTH_RST  = FW_W'(MAX_WIDTH);
	localparam logic [FH_W-1:0] FRAME_HEIGHT_RST = FH_W'(1);

	function automatic logic [7:0] med8(input logic [7:0] a, input logic [7:0] b,
			input logic [7:0] c);
		logic [7:0] lo;
		logic [7:0] hi;
		lo = (a < b) ? a : b;
		hi = (a < b) ? b : a;
		if (c >= hi) begin
			med8 = lo;
		end else if (c <= lo) begin
			med8 = hi;
		end else begin
			med8 = a + b - c;
		end
	endfunction

endpackage

`default_nettype wire

// File: hw/rtl/mrpc_if.sv
// Valid/ready request channels for pixels into and results out of the coder.
// No dependencies.
`default_nettype none

interface mrpc_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] in_first;
	logic [7:0] in_second;
	logic [7:0] in_third;

	modport source (output valid, output in_first, output in_second, output in_third,
		input ready);
	modport sink (input valid, input in_first, input in_second, input in_third,
		output ready);
endinterface

interface mrpc_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_first;
	logic [7:0] out_second;
	logic [7:0] out_third;
	logic       frame_last;

	modport source (output valid, output out_first, output out_second, output out_third,
		output frame_last, input ready);
	modport sink (input valid, input out_first, input out_second, input out_third,
		input frame_last, output ready);
endinterface

`default_nettype wire

// File: hw/rtl/mrpc_ram.sv
// Generic single-clock RAM with one write port and one registered read port.
// Reads return the old contents when the same address is written.
`default_nettype none

module mrpc_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire

// File: hw/rtl/med_residual_pixel_coder_core.sv
// Top level of the residual pixel coder: position counters, line store,
// predictor stage and output register. Uses mrpc_pkg, mrpc_if and mrpc_ram.
`default_nettype none

// Takes one pixel per cycle in raster order unless pix_out.ready stalls, and
// returns one result per pixel via the predictor stage and output register.
// The rate is set by the line store, a 4096 x 24 RAM read when a pixel is
// accepted and written back as it leaves the predictor stage. When a row is
// one pixel wide the pending write is forwarded to the next read. The line
// store needs no clearing pass after reset. Write the registers only while
// no pixel is in flight; a new width or height applies from the next pixel.
module med_residual_pixel_coder_core (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	mrpc_in_if.sink                        pix_in,
	mrpc_out_if.source                     pix_out,
	input  wire logic                      psel,
	input  wire logic                      penable,
	input  wire logic                      pwrite,
	input  wire logic [mrpc_pkg::ADDR_W-1:0] paddr,
	input  wire logic [mrpc_pkg::DATA_W-1:0] pwdata,
	output logic      [mrpc_pkg::DATA_W-1:0] prdata,
	output logic                           pready
);
	import mrpc_pkg::*;

	logic            decode_mode_q;
	logic [FW_W-1:0] frame_width_q;
	logic [FH_W-1:0] frame_height_q;

	logic [COL_W-1:0] col_q;
	logic [FH_W-1:0]  row_q;
	logic [PIX_W-1:0] left_q;
	logic [PIX_W-1:0] upleft_q;

	logic             valid_s1;
	logic [7:0]       x0_s1, x1_s1, x2_s1;
	logic             has_left_s1, has_up_s1, last_s1, row_end_s1, fwd_s1;
	logic [COL_W-1:0] col_s1;
	logic [PIX_W-1:0] fwd_data_s1;

	logic             out_valid_q;
	logic [7:0]       out_first_q, out_second_q, out_third_q;
	logic             out_last_q;

	logic             adv, accept, done;
	logic [FW_W-1:0]  w_eff;
	logic [FH_W-1:0]  h_eff;
	logic             row_end, frame_end;
	logic [PIX_W-1:0] ram_rdata, above, cur;
	logic [7:0]       a [3];
	logic [7:0]       b [3];
	logic [7:0]       c [3];
	logic [7:0]       pred [3];
	logic [7:0]       res [3];
	logic [7:0]       o0, o1, o2;

	// Configuration port.
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			decode_mode_q  <= 1'b0;
			frame_width_q  <= FRAME_WIDTH_RST;
			frame_height_q <= FRAME_HEIGHT_RST;
		end else if (psel && penable && pwrite) begin
			unique case (paddr[3:2])
				REG_DECODE_MODE:  decode_mode_q  <= pwdata[0];
				REG_FRAME_WIDTH:  frame_width_q  <= pwdata[FW_W-1:0];
				REG_FRAME_HEIGHT: frame_height_q <= pwdata[FH_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[3:2])
			REG_DECODE_MODE:  prdata = DATA_W'(decode_mode_q);
			REG_FRAME_WIDTH:  prdata = DATA_W'(frame_width_q);
			REG_FRAME_HEIGHT: prdata = DATA_W'(frame_height_q);
			default:          prdata = '0;
		endcase
	end

	// Handshake and position.
	assign adv          = !out_valid_q || pix_out.ready;
	assign pix_in.ready = !valid_s1 || adv;
	assign accept       = pix_in.valid && pix_in.ready;
	assign done         = valid_s1 && adv;

	always_comb begin
		if (frame_width_q == '0) begin
			w_eff = FW_W'(1);
		end else if (frame_width_q > FW_W'(MAX_WIDTH)) begin
			w_eff = FW_W'(MAX_WIDTH);
		end else begin
			w_eff = frame_width_q;
		end
		h_eff     = (frame_height_q == '0) ? FH_W'(1) : frame_height_q;
		row_end   = ({1'b0, col_q} + FW_W'(1)) >= w_eff;
		frame_end = row_end && (({1'b0, row_q} + 17'd1) >= {1'b0, h_eff});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (accept) begin
			if (row_end) begin
				col_q <= '0;
				row_q <= frame_end ? '0 : row_q + FH_W'(1);
			end else begin
				col_q <= col_q + COL_W'(1);
			end
		end
	end

	mrpc_ram #(
		.WIDTH(PIX_W),
		.DEPTH(MAX_WIDTH)
	) u_line_store (
		.clk  (clk),
		.we   (done),
		.waddr(col_s1),
		.wdata(cur),
		.re   (accept),
		.raddr(col_q),
		.rdata(ram_rdata)
	);

	// Predictor stage.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (done) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			x0_s1       <= pix_in.in_first;
			x1_s1       <= pix_in.in_second;
			x2_s1       <= pix_in.in_third;
			has_left_s1 <= col_q != '0;
			has_up_s1   <= row_q != '0;
			last_s1     <= frame_end;
			row_end_s1  <= row_end;
			col_s1      <= col_q;
			fwd_s1      <= done && (col_s1 == col_q);
			fwd_data_s1 <= cur;
		end
	end

	assign above = fwd_s1 ? fwd_data_s1 : ram_rdata;

	always_comb begin
		for (int k = 0; k < 3; k++) begin
			a[k]    = has_left_s1 ? left_q[8*k +: 8] : 8'd0;
			b[k]    = has_up_s1 ? above[8*k +: 8] : 8'd0;
			c[k]    = (has_left_s1 && has_up_s1) ? upleft_q[8*k +: 8] : 8'd0;
			pred[k] = med8(a[k], b[k], c[k]);
		end
		if (decode_mode_q) begin
			cur[7:0]   = x0_s1 + pred[0];
			cur[15:8]  = x1_s1 + pred[1];
			cur[23:16] = x2_s1 + pred[2];
			res[0]     = 8'd0;
			res[1]     = 8'd0;
			res[2]     = 8'd0;
			o0         = cur[15:8] + cur[7:0];
			o1         = cur[7:0];
			o2         = cur[23:16] + cur[7:0];
		end else begin
			cur[7:0]   = x1_s1;
			cur[15:8]  = x0_s1 - x1_s1;
			cur[23:16] = x2_s1 - x1_s1;
			res[0]     = cur[7:0] - pred[0];
			res[1]     = cur[15:8] - pred[1];
			res[2]     = cur[23:16] - pred[2];
			o0         = res[0];
			o1         = res[1];
			o2         = res[2];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			left_q   <= '0;
			upleft_q <= '0;
		end else if (done) begin
			if (row_end_s1) begin
				left_q   <= '0;
				upleft_q <= '0;
			end else begin
				left_q   <= cur;
				upleft_q <= above;
			end
		end
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (done) begin
			out_first_q  <= o0;
			out_second_q <= o1;
			out_third_q  <= o2;
			out_last_q   <= last_s1;
		end
	end

	assign pix_out.valid      = out_valid_q;
	assign pix_out.out_first  = out_first_q;
	assign pix_out.out_second = out_second_q;
	assign pix_out.out_third  = out_third_q;
	assign pix_out.frame_last = out_last_q;

endmodule

`default_nettype wire

// File: bench/med_residual_pixel_coder_core_tb.sv
// Self-checking bench for med_residual_pixel_coder_core: streams pixels in both coding modes
// and compares every result with an in-bench median-edge predictor. Needs mrpc_pkg,
// the mrpc_in_if/mrpc_out_if channel interfaces and the core RTL.
`timescale 1ns / 100ps

module med_residual_pixel_coder_core_tb;
	import mrpc_pkg::*;

	localparam int ITEM_TARGET    = 1300;
	localparam int HOLD_CYCLES    = 150;
	localparam int WATCHDOG_LIMIT = 1000;
	localparam logic [1:0] REG_UNUSED = 2'd3;

	typedef struct packed {
		logic [7:0] first;
		logic [7:0] second;
		logic [7:0] third;
	} pixel_t;

	typedef struct packed {
		logic [7:0] first;
		logic [7:0] second;
		logic [7:0] third;
		logic       last;
	} coded_t;

	logic clk;
	logic arst_n;
	logic psel;
	logic penable;
	logic pwrite;
	logic [ADDR_W-1:0] paddr;
	logic [DATA_W-1:0] pwdata;
	logic [DATA_W-1:0] prdata;
	logic pready;

	mrpc_in_if  in_ch ();
	mrpc_out_if out_ch ();

	med_residual_pixel_coder_core dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.pix_in  (in_ch),
		.pix_out (out_ch),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	pixel_t pixel_in_q[$];
	coded_t pixel_out_q[$];

	bit          dec_mode;
	logic [12:0] width_cfg;
	logic [15:0] height_cfg;
	bit [23:0]   line_buf [MAX_WIDTH];
	bit [23:0]   left_px;
	bit [23:0]   upleft_px;
	int unsigned col_pos;
	int unsigned row_pos;
	int unsigned store_filled;

	int send_idle_pct;
	int recv_idle_pct;
	bit hold_req;
	int stall_left;
	int idle_cycles;
	int mismatches;
	coded_t want_px;

	always #1 clk = ~clk;

	function automatic logic [7:0] edge_median(input logic [7:0] a, input logic [7:0] b,
			input logic [7:0] c);
		logic [7:0] lo;
		logic [7:0] hi;
		{lo, hi} = (a < b) ? {a, b} : {b, a};
		if (c >= hi)
			return lo;
		if (c <= lo)
			return hi;
		return a + b - c;
	endfunction

	function automatic int unsigned eff_width(input logic [12:0] v);
		if (v == 13'd0)
			return 1;
		if (v > 13'(MAX_WIDTH))
			return MAX_WIDTH;
		return {19'd0, v};
	endfunction

	function automatic coded_t code_pixel(input pixel_t px);
		int unsigned w;
		int unsigned h;
		bit          has_left;
		bit          has_up;
		bit          row_end;
		bit          frame_end;
		bit [23:0]   above;
		logic [7:0]  inp [3];
		logic [7:0]  val [3];
		logic [7:0]  rsd [3];
		logic [7:0]  a;
		logic [7:0]  b;
		logic [7:0]  c;
		logic [7:0]  pred;
		coded_t      res;
		w = eff_width(width_cfg);
		h = (height_cfg == 16'd0) ? 1 : {16'd0, height_cfg};
		has_left = col_pos > 0;
		has_up = row_pos > 0;
		above = line_buf[col_pos];
		inp = '{px.first, px.second, px.third};
		val[0] = px.second;
		val[1] = px.first - px.second;
		val[2] = px.third - px.second;
		for (int k = 0; k < 3; k++) begin
			a = has_left ? left_px[8*k +: 8] : 8'd0;
			b = has_up ? above[8*k +: 8] : 8'd0;
			c = (has_left && has_up) ? upleft_px[8*k +: 8] : 8'd0;
			pred = edge_median(a, b, c);
			if (dec_mode) begin
				val[k] = inp[k] + pred;
			end else begin
				rsd[k] = val[k] - pred;
			end
		end
		if (dec_mode) begin
			res.first = val[1] + val[0];
			res.second = val[0];
			res.third = val[2] + val[0];
		end else begin
			res.first = rsd[0];
			res.second = rsd[1];
			res.third = rsd[2];
		end
		row_end = col_pos + 1 >= w;
		frame_end = row_end && (row_pos + 1 >= h);
		res.last = frame_end;
		line_buf[col_pos] = {val[2], val[1], val[0]};
		upleft_px = above;
		left_px = {val[2], val[1], val[0]};
		if (col_pos + 1 > store_filled)
			store_filled = col_pos + 1;
		if (row_end) begin
			col_pos = 0;
			row_pos = frame_end ? 0 : row_pos + 1;
			left_px = '0;
			upleft_px = '0;
		end else begin
			col_pos = col_pos + 1;
		end
		return res;
	endfunction

	task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
		if (got !== want) begin
			$display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
			mismatches++;
		end
	endtask

	// Input side: a request that is not taken stays on the bus unchanged.
	always @(posedge clk) begin
		if (in_ch.valid && in_ch.ready)
			pixel_out_q.push_back(code_pixel(pixel_in_q.pop_front()));
		if (!(in_ch.valid && !in_ch.ready)) begin
			if (pixel_in_q.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
				in_ch.valid <= 1'b1;
				in_ch.in_first <= pixel_in_q[0].first;
				in_ch.in_second <= pixel_in_q[0].second;
				in_ch.in_third <= pixel_in_q[0].third;
			end else begin
				in_ch.valid <= 1'b0;
			end
		end
	end

	always @(posedge clk) begin
		if (out_ch.valid && out_ch.ready) begin
			if (pixel_out_q.size() == 0) begin
				$display("%0t ns: unexpected result, expected none, actual %0d %0d %0d last %0d",
					$time, out_ch.out_first, out_ch.out_second, out_ch.out_third,
					out_ch.frame_last);
				mismatches++;
			end else begin
				want_px = pixel_out_q.pop_front();
				check_field("out_first", want_px.first, out_ch.out_first);
				check_field("out_second", want_px.second, out_ch.out_second);
				check_field("out_third", want_px.third, out_ch.out_third);
				check_field("frame_last", {7'd0, want_px.last}, {7'd0, out_ch.frame_last});
			end
		end
		if (stall_left > 0) begin
			stall_left--;
			out_ch.ready <= 1'b0;
		end else if (hold_req) begin
			hold_req = 1'b0;
			stall_left = HOLD_CYCLES;
			out_ch.ready <= 1'b0;
		end else begin
			out_ch.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
		end
	end

	always @(posedge clk) begin
		if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("[med_residual_pixel_coder_core] ERROR");
			$finish;
		end
	end

	task automatic reg_write(input logic [1:0] idx, input logic [31:0] val);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= val;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(negedge clk);
		case (idx)
			REG_DECODE_MODE: dec_mode = val[0];
			REG_FRAME_WIDTH: width_cfg = val[FW_W-1:0];
			REG_FRAME_HEIGHT: height_cfg = val[FH_W-1:0];
			default: ;
		endcase
	endtask

	task automatic wait_drained();
		do
			@(negedge clk);
		while (pixel_in_q.size() > 0 || pixel_out_q.size() > 0);
	endtask

	task automatic queue_pixel(input logic [7:0] f, input logic [7:0] s, input logic [7:0] t);
		pixel_in_q.push_back('{f, s, t});
	endtask

	task automatic set_idle(input int mode);
		send_idle_pct = (mode == 0) ? 28 : (mode == 1) ? 47 : 0;
		recv_idle_pct = (mode == 0) ? 47 : (mode == 1) ? 28 : 0;
	endtask

	initial begin
		int          queued;
		int          phase_no;
		int          mode;
		int          n_items;
		bit          smooth;
		bit          stall_done;
		logic [12:0] w_req;
		logic [15:0] h_req;
		pixel_t      px;
		pixel_t      walk;
		clk = 1'b0;
		arst_n = 1'b0;
		in_ch.valid = 1'b0;
		in_ch.in_first = '0;
		in_ch.in_second = '0;
		in_ch.in_third = '0;
		out_ch.ready = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		dec_mode = 1'b0;
		width_cfg = FRAME_WIDTH_RST;
		height_cfg = FRAME_HEIGHT_RST;
		left_px = '0;
		upleft_px = '0;
		col_pos = 0;
		row_pos = 0;
		store_filled = 0;
		hold_req = 1'b0;
		stall_left = 0;
		idle_cycles = 0;
		mismatches = 0;
		stall_done = 1'b0;
		walk = '0;
		set_idle(0);
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Reset settings: one long row, so no pixel here closes a frame.
		queue_pixel(8'd255, 8'd0, 8'd255);
		queue_pixel(8'd0, 8'd255, 8'd0);
		queue_pixel(8'd255, 8'd255, 8'd0);
		wait_drained();

		// Narrowing mid-row: the pending column already lies past the new width.
		reg_write(REG_FRAME_WIDTH, 32'd3);
		reg_write(REG_FRAME_HEIGHT, 32'd2);
		queue_pixel(8'd10, 8'd200, 8'd30);
		queue_pixel(8'd200, 8'd10, 8'd250);
		queue_pixel(8'd0, 8'd0, 8'd0);
		queue_pixel(8'd128, 8'd64, 8'd32);
		wait_drained();

		// One-pixel rows in decode mode, where each read needs the previous write.
		reg_write(REG_DECODE_MODE, 32'd1);
		reg_write(REG_FRAME_WIDTH, 32'd1);
		reg_write(REG_FRAME_HEIGHT, 32'd3);
		queue_pixel(8'd0, 8'd0, 8'd0);
		queue_pixel(8'd255, 8'd255, 8'd255);
		queue_pixel(8'd1, 8'd128, 8'd254);
		queue_pixel(8'd0, 8'd0, 8'd0);
		wait_drained();

		// Zero width and height act as one; the current row lies past the new height.
		reg_write(REG_FRAME_WIDTH, 32'd0);
		reg_write(REG_FRAME_HEIGHT, 32'd0);
		reg_write(REG_UNUSED, 32'hFFFF_FFFF);
		reg_write(REG_DECODE_MODE, 32'd0);
		queue_pixel(8'd255, 8'd255, 8'd255);
		queue_pixel(8'd0, 8'd128, 8'd255);
		queue_pixel(8'd77, 8'd77, 8'd77);
		wait_drained();

		reg_write(REG_FRAME_WIDTH, 32'd8191);
		reg_write(REG_FRAME_HEIGHT, 32'd2);
		reg_write(REG_DECODE_MODE, 32'd1);
		repeat (4)
			queue_pixel(8'($urandom()), 8'($urandom()), 8'($urandom()));
		queued = 18;
		phase_no = 0;

		while (queued < ITEM_TARGET) begin
			wait_drained();
			mode = (queued < ITEM_TARGET / 3) ? 0 : (queued < 2 * ITEM_TARGET / 3) ? 1 : 2;
			set_idle(mode);
			if (mode == 2 && !stall_done) begin
				hold_req = 1'b1;
				stall_done = 1'b1;
			end
			if ($urandom_range(0, 1))
				reg_write(REG_DECODE_MODE, ($urandom() & ~32'h1) | $urandom_range(0, 1));
			n_items = $urandom_range(20, 70);
			if (phase_no == 3) begin
				w_req = 13'($urandom_range(100, 300));
				h_req = 16'd2;
			end else begin
				case ($urandom_range(0, 9))
					0, 1, 2, 3, 4, 5: w_req = 13'($urandom_range(1, 12));
					6: w_req = 13'd1;
					7: w_req = 13'($urandom_range(13, 80));
					8: w_req = 13'd4096;
					default: w_req = 13'($urandom_range(0, 8191));
				endcase
				case ($urandom_range(0, 9))
					0, 1, 2, 3, 4, 5, 6: h_req = 16'($urandom_range(1, 6));
					7: h_req = 16'd0;
					8: h_req = 16'($urandom_range(7, 40));
					default: h_req = 16'hFFFF;
				endcase
			end
			// A wider row in mid-frame must not reach line-store entries never written.
			if (row_pos > 0 && eff_width(w_req) > store_filled)
				w_req = 13'(store_filled);
			if (phase_no == 3 || $urandom_range(0, 1)) begin
				reg_write(REG_FRAME_WIDTH, ($urandom() & ~32'h1FFF) | {19'd0, w_req});
				reg_write(REG_FRAME_HEIGHT, ($urandom() & ~32'hFFFF) | {16'd0, h_req});
			end
			if (phase_no == 3)
				n_items = 2 * eff_width(width_cfg) + 3;
			smooth = $urandom_range(0, 1);
			for (int i = 0; i < n_items; i++) begin
				if (!smooth) begin
					px = 24'($urandom());
				end else if (dec_mode) begin
					px.first = 8'($urandom_range(0, 4)) - 8'd2;
					px.second = 8'($urandom_range(0, 4)) - 8'd2;
					px.third = 8'($urandom_range(0, 4)) - 8'd2;
				end else begin
					walk.first = walk.first + 8'($urandom_range(0, 6)) - 8'd3;
					walk.second = walk.second + 8'($urandom_range(0, 6)) - 8'd3;
					walk.third = walk.third + 8'($urandom_range(0, 6)) - 8'd3;
					px = walk;
				end
				pixel_in_q.push_back(px);
			end
			queued += n_items;
			phase_no++;
		end

		wait_drained();
		repeat (8) @(posedge clk);
		if (mismatches == 0 && pixel_out_q.size() == 0) begin
			$display("[med_residual_pixel_coder_core] OK");
		end else begin
			$display("[med_residual_pixel_coder_core] ERROR");
		end
		$finish;
	end

endmodule

// File: filelist.f
hw/rtl/mrpc_pkg.sv
hw/rtl/mrpc_if.sv
hw/rtl/mrpc_ram.sv
hw/rtl/med_residual_pixel_coder_core.sv
bench/med_residual_pixel_coder_core_tb.sv
